### rtl/string_to_signed_integer_parser_macros.svh
// Assertion macros for the string to signed integer parser.
// Included by the top level; depends on nothing else.
`ifndef STRING_TO_SIGNED_INTEGER_PARSER_MACROS_SVH
`define STRING_TO_SIGNED_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define STOI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define STOI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/stoi_pkg.sv
// Shared types, constants and character helpers for the string parser.
// Used by stoi_accum, stoi_finish and string_to_signed_integer_parser.
package stoi_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX  = 1'b0,
    REG_NARROW = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_DONE   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_PREFIX = 3'd4,
    PH_DIGITS = 3'd5
  } phase_e;

  localparam logic [6:0] NO_DIGIT = 7'd99;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [5:0] MAX_BASE = 6'd36;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LB    = 8'h62;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S32_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] S32_MIN = 64'hFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [63:0] number;
    logic        success;
    logic [15:0] consumed;
    logic        overflowed;
  } res_t;

  typedef struct packed {
    logic [63:0] acc;
    logic        ovf;
  } acc_res_t;

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [6:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 7'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = 7'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = 7'(c - 8'h41 + 8'd10);
    end else begin
      d = NO_DIGIT;
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

### rtl/string_to_signed_integer_parser.sv
// Streaming strtoll-style parser top level: input register, parse state, result register.
// Depends on stoi_pkg, stoi_accum, stoi_finish and the assertion macro header.
//
// The block takes one character per cycle while the result side is ready and, at the character
// that ends a number, presents one result from the result register, which the input register
// feeds directly; the result is loaded when that character leaves the input register. Throughput
// is one character per cycle whenever the result side is ready; the cycle is set by the accumulate
// step, a 64-by-6 multiply followed by a subtract for the overflow test and the digit add. The base
// is taken from the radix on the character marked first; narrow_mode is applied when the result is
// formed. There is no clearing pass after reset.
module string_to_signed_integer_parser #(
  parameter int unsigned COUNT_WIDTH = stoi_pkg::COUNT_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stoi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stoi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     ch_i,
  input  logic                           first_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [63:0]                    number_o,
  output logic                           success_o,
  output logic [15:0]                    consumed_o,
  output logic                           overflowed_o
);

  `include "string_to_signed_integer_parser_macros.svh"

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic       emit;
    logic       fail;
    logic       acc_en;
    logic [1:0] inc;
    logic       neg_ld;
    logic       neg_val;
    logic       base_ld;
    logic [5:0] base;
  } ctl_t;

  // configuration
  logic [5:0] radix_q;
  logic       narrow_mode_q;

  // input register
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       first_q;

  // parse state
  stoi_pkg::phase_e        phase_q, phase_d, phase_eff;
  logic [63:0]             acc_q, acc_d, acc_eff;
  logic                    ovf_q, ovf_d, ovf_eff;
  logic                    neg_q, neg_d, neg_eff;
  logic [5:0]              base_q, base_d, base_eff;
  logic [COUNT_WIDTH-1:0]  cnt_q, cnt_d, cnt_eff;
  logic [COUNT_WIDTH:0]    cnt_sum;

  // result register
  logic           out_valid_q;
  stoi_pkg::res_t res_q;
  stoi_pkg::res_t fin_res;
  stoi_pkg::acc_res_t acc_res;

  logic       out_free;
  logic       fire;
  logic       bad_radix;
  logic [7:0] lc;
  logic [6:0] dig;
  ctl_t       ctl;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || fire;

  assign lc        = ch_q | stoi_pkg::CASE_BIT;
  assign dig       = stoi_pkg::digit_of(ch_q);
  assign bad_radix = radix_q > stoi_pkg::MAX_BASE;

  // a first character drops any unfinished parse
  always_comb begin
    if (first_q) begin
      phase_eff = bad_radix ? stoi_pkg::PH_DONE : stoi_pkg::PH_LEAD;
      acc_eff   = 64'd0;
      ovf_eff   = 1'b0;
      neg_eff   = 1'b0;
      base_eff  = radix_q;
      cnt_eff   = '0;
    end else begin
      phase_eff = phase_q;
      acc_eff   = acc_q;
      ovf_eff   = ovf_q;
      neg_eff   = neg_q;
      base_eff  = base_q;
      cnt_eff   = cnt_q;
    end
  end

  // next state and step control
  always_comb begin
    logic       start_path;
    logic [5:0] b;
    start_path = 1'b0;
    b          = base_eff;
    phase_d    = phase_q;
    ctl        = '0;
    ctl.base   = base_eff;
    if (fire) begin
      phase_d = phase_eff;
      if (first_q && bad_radix) begin
        ctl.emit = 1'b1;
        ctl.fail = 1'b1;
        phase_d  = stoi_pkg::PH_DONE;
      end else begin
        case (phase_eff)
          stoi_pkg::PH_DONE: begin
            phase_d = stoi_pkg::PH_DONE;
          end
          stoi_pkg::PH_LEAD: begin
            if (stoi_pkg::is_space(ch_q)) begin
              ctl.inc = 2'd1;
            end else if (ch_q == stoi_pkg::CH_MINUS || ch_q == stoi_pkg::CH_PLUS) begin
              ctl.inc     = 2'd1;
              ctl.neg_ld  = 1'b1;
              ctl.neg_val = (ch_q == stoi_pkg::CH_MINUS);
              phase_d     = stoi_pkg::PH_SIGNED;
            end else begin
              start_path = 1'b1;
            end
          end
          stoi_pkg::PH_SIGNED: begin
            start_path = 1'b1;
          end
          stoi_pkg::PH_ZERO: begin
            if (lc == stoi_pkg::CH_LX && (base_eff == 6'd16 || base_eff == 6'd0)) begin
              ctl.base_ld = 1'b1;
              ctl.base    = 6'd16;
              phase_d     = stoi_pkg::PH_PREFIX;
            end else if (lc == stoi_pkg::CH_LB && (base_eff == 6'd2 || base_eff == 6'd0)) begin
              ctl.base_ld = 1'b1;
              ctl.base    = 6'd2;
              phase_d     = stoi_pkg::PH_PREFIX;
            end else begin
              // a bare leading zero in detect mode means octal
              b           = (base_eff == 6'd0) ? 6'd8 : base_eff;
              ctl.base_ld = 1'b1;
              ctl.base    = b;
              if (dig < {1'b0, b}) begin
                ctl.acc_en = 1'b1;
                ctl.inc    = 2'd1;
                phase_d    = stoi_pkg::PH_DIGITS;
              end else begin
                ctl.emit = 1'b1;
                phase_d  = stoi_pkg::PH_DONE;
              end
            end
          end
          stoi_pkg::PH_PREFIX: begin
            // the prefix letter is counted together with its first digit
            if (dig < {1'b0, base_eff}) begin
              ctl.acc_en = 1'b1;
              ctl.inc    = 2'd2;
              phase_d    = stoi_pkg::PH_DIGITS;
            end else begin
              ctl.emit = 1'b1;
              phase_d  = stoi_pkg::PH_DONE;
            end
          end
          stoi_pkg::PH_DIGITS: begin
            if (dig < {1'b0, base_eff}) begin
              ctl.acc_en = 1'b1;
              ctl.inc    = 2'd1;
            end else begin
              ctl.emit = 1'b1;
              phase_d  = stoi_pkg::PH_DONE;
            end
          end
          default: begin
            phase_d = stoi_pkg::PH_DONE;
          end
        endcase
        if (start_path) begin
          if (ch_q == stoi_pkg::CH_ZERO && base_eff != 6'd10) begin
            ctl.inc = 2'd1;
            phase_d = stoi_pkg::PH_ZERO;
          end else begin
            b           = (base_eff == 6'd0) ? 6'd10 : base_eff;
            ctl.base_ld = 1'b1;
            ctl.base    = b;
            if (dig < {1'b0, b}) begin
              ctl.acc_en = 1'b1;
              ctl.inc    = 2'd1;
              phase_d    = stoi_pkg::PH_DIGITS;
            end else begin
              ctl.emit = 1'b1;
              ctl.fail = 1'b1;
              phase_d  = stoi_pkg::PH_DONE;
            end
          end
        end
      end
    end
  end

  stoi_accum u_accum (
    .acc_i   (acc_eff),
    .base_i  (ctl.base),
    .digit_i (dig[5:0]),
    .res_o   (acc_res)
  );

  stoi_finish #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_finish (
    .acc_i    (acc_eff),
    .ovf_i    (ovf_eff),
    .neg_i    (neg_eff),
    .narrow_i (narrow_mode_q),
    .cnt_i    (cnt_eff),
    .res_o    (fin_res)
  );

  // datapath state update
  always_comb begin
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    neg_d   = neg_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    cnt_sum = {1'b0, cnt_eff} + (COUNT_WIDTH + 1)'(ctl.inc);
    if (fire) begin
      acc_d  = ctl.acc_en ? acc_res.acc : acc_eff;
      ovf_d  = ovf_eff | (ctl.acc_en & acc_res.ovf);
      neg_d  = ctl.neg_ld ? ctl.neg_val : neg_eff;
      base_d = ctl.base_ld ? ctl.base : base_eff;
      cnt_d  = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= '0;
      narrow_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (stoi_pkg::cfg_reg_e'(cfg_idx_i))
        stoi_pkg::REG_RADIX:  radix_q       <= cfg_data_i;
        stoi_pkg::REG_NARROW: narrow_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= stoi_pkg::PH_DONE;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      neg_q       <= 1'b0;
      base_q      <= '0;
      cnt_q       <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire && ctl.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q    <= ch_i;
      first_q <= first_i;
    end
    if (fire && ctl.emit) begin
      res_q <= ctl.fail ? '0 : fin_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign number_o     = res_q.number;
  assign success_o    = res_q.success;
  assign consumed_o   = res_q.consumed;
  assign overflowed_o = res_q.overflowed;

  `STOI_ASSERT_NOW(a_ok_not_sat, clk_i, rst_ni, out_valid_o && success_o, !overflowed_o, "success with saturation")
  `STOI_ASSERT_NOW(a_narrow_fits, clk_i, rst_ni, out_valid_o && narrow_mode_q, number_o[63:31] == '0 || number_o[63:31] == '1, "narrow result out of 32-bit range")
  `STOI_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, fire && ctl.emit, out_valid_q && phase_q == stoi_pkg::PH_DONE, "emitted result not held")
  `STOI_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, in_valid_q && !out_free, in_valid_q && $stable(ch_q) && $stable(first_q), "stalled character lost")

endmodule

### rtl/stoi_accum.sv
// One accumulate step: acc*base + digit modulo 2^64, with the overflow test.
// Depends on stoi_pkg.
module stoi_accum (
  input  logic [63:0]         acc_i,
  input  logic [5:0]          base_i,
  input  logic [5:0]          digit_i,
  output stoi_pkg::acc_res_t  res_o
);

  logic [63:0] prod;
  logic [63:0] diff;

  always_comb begin
    prod       = 64'(acc_i * {58'd0, base_i});
    diff       = prod - acc_i;
    res_o.ovf  = diff[63];
    res_o.acc  = prod + {58'd0, digit_i};
  end

endmodule

### rtl/stoi_finish.sv
// Result formatting: sign, 64-bit saturation, optional 32-bit clamp, count limit.
// Depends on stoi_pkg.
module stoi_finish #(
  parameter int unsigned COUNT_WIDTH = stoi_pkg::COUNT_WIDTH
) (
  input  logic [63:0]            acc_i,
  input  logic                   ovf_i,
  input  logic                   neg_i,
  input  logic                   narrow_i,
  input  logic [COUNT_WIDTH-1:0] cnt_i,
  output stoi_pkg::res_t         res_o
);

  logic [63:0] num;
  logic [31:0] cnt32;
  logic        ok;
  logic        sat;

  always_comb begin
    ok  = 1'b1;
    sat = 1'b0;
    if (ovf_i) begin
      num = neg_i ? stoi_pkg::S64_MIN : stoi_pkg::S64_MAX;
      ok  = 1'b0;
      sat = 1'b1;
    end else begin
      num = neg_i ? (64'd0 - acc_i) : acc_i;
    end
    if (narrow_i) begin
      if ($signed(num) < $signed(stoi_pkg::S32_MIN)) begin
        num = stoi_pkg::S32_MIN;
        ok  = 1'b0;
        sat = 1'b1;
      end else if ($signed(num) > $signed(stoi_pkg::S32_MAX)) begin
        num = stoi_pkg::S32_MAX;
        ok  = 1'b0;
        sat = 1'b1;
      end
    end
    cnt32            = 32'(cnt_i);
    res_o.number     = num;
    res_o.success    = ok;
    res_o.consumed   = (cnt32 > 32'h0000_FFFF) ? 16'hFFFF : cnt32[15:0];
    res_o.overflowed = sat;
  end

endmodule
